// ===== rtl/bud_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bud_pkg: shared types and constants
// Command and result payloads, command codes and register indexes of the
// buddy allocator.
// ----------------------------------------------------------------------------
package bud_pkg;

	localparam int ADDR_W  = 48;
	localparam int REQ_W   = 32;
	localparam int BYTES_W = 23;
	localparam int KIND_W  = 2;
	localparam int ORD_W   = 5;
	localparam int HDR_BYTES = 8;

	localparam logic [KIND_W-1:0] KIND_INIT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FREE   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_REPORT = 2'd3;

	localparam logic CFG_BASE = 1'b0;
	localparam logic CFG_SIZE = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [REQ_W-1:0]  request_size;
		logic [ADDR_W-1:0] address;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  result_address;
		logic               status;
		logic [BYTES_W-1:0] total_bytes;
		logic [BYTES_W-1:0] used_bytes;
		logic [BYTES_W-1:0] free_bytes;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/buddy_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_allocator: buddy memory allocator, block orders MIN..MAX
// Free lists live in a per-slot link RAM walked by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  - Commands enter on cmd with start; one is taken when start is high and
//    busy is low. Exactly one result follows, shown for one cycle with done.
//    The receiver cannot stall; the result must be taken when done is high.
//  - Config writes (cfg_index 0 heap base, 1 heap size) go over the
//    cfg_valid/cfg_ready channel, always ready. Values are latched by init.
//  - Steps: report, null requests and bad requests caught at decode answer
//    straight from idle. Alloc unlinks the found block (Q0..Q4), then pushes
//    the upper half back for each split order. Free checks the block, then
//    per merged order reads and unlinks the buddy, then pushes the merged
//    block. Init first sweeps the slot RAM, then pushes each carved block.
//    Every step is set by the single RAM read/write port pair: each
//    link update is a read-modify-write through it.
//  - Reset: busy stays high while the slot RAM is swept to clear the
//    free marks; all lists start empty.
//  - One command at a time; the next can be taken while done is high.
// ----------------------------------------------------------------------------
module buddy_allocator #(
	parameter int MIN_ORDER_LOG = 5,
	parameter int MAX_ORDER_LOG = 20,
	parameter int HEAP_SLOTS    = 131072
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  bud_pkg::cmd_t       cmd,
	output logic                done,
	output bud_pkg::res_t       result,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire                 cfg_index,
	input  wire [bud_pkg::ADDR_W-1:0] cfg_data
);

	localparam int NUM_ORD = MAX_ORDER_LOG - MIN_ORDER_LOG + 1;
	localparam int LW      = (NUM_ORD > 1) ? $clog2(NUM_ORD) : 1;
	localparam int SW      = $clog2(HEAP_SLOTS);
	localparam int OW      = ((MAX_ORDER_LOG > bud_pkg::BYTES_W) ?
		MAX_ORDER_LOG : bud_pkg::BYTES_W) + 2;
	localparam int OWD     = bud_pkg::ORD_W;
	localparam longint CAP = longint'(HEAP_SLOTS) << MIN_ORDER_LOG;
	// slot word layout
	localparam int NXT_LO = 0;
	localparam int NOK    = SW;
	localparam int PRV_LO = SW + 1;
	localparam int POK    = 2 * SW + 1;
	localparam int ORD_LO = 2 * SW + 2;
	localparam int MARK   = 2 * SW + 2 + OWD;
	localparam int MW     = MARK + 1;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_CARVE = 4'd2;
	localparam logic [3:0] ST_SPLIT = 4'd3;
	localparam logic [3:0] ST_FCHK  = 4'd4;
	localparam logic [3:0] ST_MERGE = 4'd5;
	localparam logic [3:0] ST_MCHK  = 4'd6;
	localparam logic [3:0] ST_MSTEP = 4'd7;
	localparam logic [3:0] ST_FDONE = 4'd8;
	localparam logic [3:0] ST_P0    = 4'd9;
	localparam logic [3:0] ST_P1    = 4'd10;
	localparam logic [3:0] ST_Q0    = 4'd11;
	localparam logic [3:0] ST_Q1    = 4'd12;
	localparam logic [3:0] ST_Q2    = 4'd13;
	localparam logic [3:0] ST_Q3    = 4'd14;
	localparam logic [3:0] ST_Q4    = 4'd15;

	localparam logic [OWD-1:0] MIN_O = OWD'(MIN_ORDER_LOG);
	localparam logic [OWD-1:0] MAX_O = OWD'(MAX_ORDER_LOG);

	function automatic logic [OW-1:0] bsz(input logic [OWD-1:0] o);
		return OW'(1) << o;
	endfunction

	function automatic logic [SW-1:0] slot_of(input logic [OW-1:0] o);
		return o[MIN_ORDER_LOG +: SW];
	endfunction

	// registers
	logic [3:0]                   st_q, ret_q;
	logic [SW-1:0]                clr_q;
	logic                         clr_init_q;
	logic [bud_pkg::ADDR_W-1:0]   cfg_base_q, live_base_q;
	logic [bud_pkg::BYTES_W-1:0]  cfg_size_q, live_size_q, carved_q, free_total_q;
	logic [SW-1:0]                head_q [NUM_ORD];
	logic [NUM_ORD-1:0]           head_ok_q;
	logic [OWD-1:0]               cur_q, tgt_q, sub_ord_q;
	logic [SW-1:0]                sub_slot_q, h_q;
	logic                         set_ord_q;
	logic [OW-1:0]                off_q, rem_q;
	logic [MW-1:0]                w_q;
	logic                         done_q;
	bud_pkg::res_t                res_q;

	// RAM
	logic          ram_we;
	logic [SW-1:0] ram_wa, ram_ra;
	logic [MW-1:0] ram_wd, rdata;

	bud_ram #(.WIDTH(MW), .DEPTH(HEAP_SLOTS)) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (ram_ra),
		.rdata (rdata)
	);

	// request decode
	logic [bud_pkg::REQ_W:0]   need;
	logic                      aok, fok;
	logic [OWD-1:0]            aord;
	logic [LW-1:0]             fidx;
	logic [bud_pkg::ADDR_W-1:0] foff;
	logic                      fbad;
	logic [LW-1:0]             sub_li;
	logic [OW-1:0]             bs_cur, bud;
	logic [OWD-1:0]            r_ord;
	logic [OW-1:0]             r_bs;
	logic                      r_bad;
	logic                      take;

	assign take = start && (st_q == ST_IDLE);
	assign sub_li = LW'(sub_ord_q - MIN_O);
	assign bs_cur = bsz(cur_q);
	assign bud    = off_q ^ bs_cur;
	assign r_ord  = rdata[ORD_LO +: OWD];
	assign r_bs   = bsz(r_ord);

	always_comb begin
		need = {1'b0, cmd.request_size} + (bud_pkg::REQ_W+1)'(bud_pkg::HDR_BYTES);
		aok  = 1'b0;
		aord = MIN_O;
		for (int k = MAX_ORDER_LOG; k >= MIN_ORDER_LOG; k--) begin
			if (((bud_pkg::REQ_W+1)'(1) << k) >= need) begin
				aok  = 1'b1;
				aord = OWD'(k);
			end
		end
		fok  = 1'b0;
		fidx = '0;
		for (int i = NUM_ORD - 1; i >= 0; i--) begin
			if (head_ok_q[i] && (OWD'(i) + MIN_O >= aord)) begin
				fok  = 1'b1;
				fidx = LW'(i);
			end
		end
		foff = cmd.address - live_base_q - bud_pkg::ADDR_W'(bud_pkg::HDR_BYTES);
		fbad = (foff[MIN_ORDER_LOG-1:0] != '0) ||
			(foff >= bud_pkg::ADDR_W'(carved_q));
		// block at the freed slot must be live, in range and aligned
		r_bad = rdata[MARK] || (r_ord < MIN_O) || (r_ord > MAX_O) ||
			((off_q & (r_bs - OW'(1))) != '0) ||
			((off_q + r_bs) > OW'(carved_q));
	end

	// RAM port control
	always_comb begin
		ram_we = 1'b0;
		ram_wa = sub_slot_q;
		ram_wd = w_q;
		ram_ra = sub_slot_q;
		unique case (st_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_wa = clr_q;
				ram_wd = '0;
			end
			ST_IDLE: begin
				ram_ra = foff[MIN_ORDER_LOG +: SW];
			end
			ST_P0: begin
				// new head: links to the old head, marked free
				ram_we = 1'b1;
				ram_wd = '0;
				ram_wd[MARK] = 1'b1;
				ram_wd[ORD_LO +: OWD] = sub_ord_q;
				ram_wd[NOK] = head_ok_q[sub_li];
				ram_wd[NXT_LO +: SW] = head_q[sub_li];
				ram_ra = head_q[sub_li];
			end
			ST_P1: begin
				ram_we = 1'b1;
				ram_wa = h_q;
				ram_wd = rdata;
				ram_wd[POK] = 1'b1;
				ram_wd[PRV_LO +: SW] = sub_slot_q;
			end
			ST_Q1: begin
				ram_ra = rdata[PRV_LO +: SW];
			end
			ST_Q2: begin
				ram_we = w_q[POK];
				ram_wa = w_q[PRV_LO +: SW];
				ram_wd = rdata;
				ram_wd[NOK] = w_q[NOK];
				ram_wd[NXT_LO +: SW] = w_q[NXT_LO +: SW];
				ram_ra = w_q[NXT_LO +: SW];
			end
			ST_Q3: begin
				ram_we = w_q[NOK];
				ram_wa = w_q[NXT_LO +: SW];
				ram_wd = rdata;
				ram_wd[POK] = w_q[POK];
				ram_wd[PRV_LO +: SW] = w_q[PRV_LO +: SW];
			end
			ST_Q4: begin
				ram_we = 1'b1;
				ram_wd = w_q;
				ram_wd[NOK]  = 1'b0;
				ram_wd[POK]  = 1'b0;
				ram_wd[MARK] = 1'b0;
				if (set_ord_q) begin
					ram_wd[ORD_LO +: OWD] = tgt_q;
				end
			end
			ST_MERGE: begin
				ram_ra = slot_of(bud);
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_CLEAR;
			ret_q        <= ST_IDLE;
			clr_q        <= '0;
			clr_init_q   <= 1'b0;
			cfg_base_q   <= '0;
			cfg_size_q   <= '0;
			live_base_q  <= '0;
			live_size_q  <= '0;
			carved_q     <= '0;
			free_total_q <= '0;
			head_ok_q    <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == bud_pkg::CFG_BASE) begin
					cfg_base_q <= cfg_data;
				end else begin
					cfg_size_q <= cfg_data[bud_pkg::BYTES_W-1:0];
				end
			end
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(HEAP_SLOTS - 1)) begin
						clr_q <= '0;
						st_q  <= clr_init_q ? ST_CARVE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						res_q <= '0;
						unique case (cmd.kind)
							bud_pkg::KIND_INIT: begin
								live_base_q  <= cfg_base_q;
								live_size_q  <= cfg_size_q;
								if (64'(cfg_size_q) < 64'(CAP)) begin
									carved_q <= cfg_size_q;
									rem_q    <= OW'(cfg_size_q);
								end else begin
									carved_q <= bud_pkg::BYTES_W'(CAP);
									rem_q    <= OW'(CAP);
								end
								head_ok_q    <= '0;
								free_total_q <= '0;
								off_q        <= '0;
								cur_q        <= MAX_O;
								clr_init_q   <= 1'b1;
								st_q         <= ST_CLEAR;
							end
							bud_pkg::KIND_ALLOC: begin
								if (cmd.request_size != '0 && aok && fok) begin
									sub_ord_q  <= OWD'(fidx) + MIN_O;
									cur_q      <= OWD'(fidx) + MIN_O;
									sub_slot_q <= head_q[fidx];
									off_q      <= OW'(head_q[fidx]) << MIN_ORDER_LOG;
									tgt_q      <= aord;
									set_ord_q  <= 1'b1;
									ret_q      <= ST_SPLIT;
									st_q       <= ST_Q0;
								end else begin
									res_q.status <= 1'b1;
									done_q       <= 1'b1;
								end
							end
							bud_pkg::KIND_FREE: begin
								if (cmd.address == '0) begin
									done_q <= 1'b1;
								end else if (fbad) begin
									res_q.status <= 1'b1;
									done_q       <= 1'b1;
								end else begin
									off_q <= OW'(foff);
									st_q  <= ST_FCHK;
								end
							end
							default: begin
								res_q.total_bytes <= live_size_q;
								res_q.used_bytes  <= live_size_q - free_total_q;
								res_q.free_bytes  <= free_total_q;
								done_q            <= 1'b1;
							end
						endcase
					end
				end
				ST_CARVE: begin
					if (rem_q == '0 || cur_q < MIN_O) begin
						done_q <= 1'b1;
						st_q   <= ST_IDLE;
					end else if (rem_q >= bs_cur) begin
						sub_ord_q  <= cur_q;
						sub_slot_q <= slot_of(off_q);
						off_q      <= off_q + bs_cur;
						rem_q      <= rem_q - bs_cur;
						ret_q      <= ST_CARVE;
						st_q       <= ST_P0;
					end else begin
						cur_q <= cur_q - OWD'(1);
					end
				end
				ST_SPLIT: begin
					if (cur_q > tgt_q) begin
						// upper half of the split goes back on its list
						sub_ord_q  <= cur_q - OWD'(1);
						sub_slot_q <= slot_of(off_q + bsz(cur_q - OWD'(1)));
						cur_q      <= cur_q - OWD'(1);
						ret_q      <= ST_SPLIT;
						st_q       <= ST_P0;
					end else begin
						res_q.result_address <= live_base_q + bud_pkg::ADDR_W'(off_q) +
							bud_pkg::ADDR_W'(bud_pkg::HDR_BYTES);
						done_q <= 1'b1;
						st_q   <= ST_IDLE;
					end
				end
				ST_FCHK: begin
					if (r_bad) begin
						res_q.status <= 1'b1;
						done_q       <= 1'b1;
						st_q         <= ST_IDLE;
					end else begin
						cur_q <= r_ord;
						st_q  <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					if (cur_q < MAX_O && (bud + bs_cur) <= OW'(carved_q)) begin
						st_q <= ST_MCHK;
					end else begin
						sub_ord_q  <= cur_q;
						sub_slot_q <= slot_of(off_q);
						ret_q      <= ST_FDONE;
						st_q       <= ST_P0;
					end
				end
				ST_MCHK: begin
					sub_ord_q <= cur_q;
					set_ord_q <= 1'b0;
					if (rdata[MARK] && r_ord == cur_q) begin
						sub_slot_q <= slot_of(bud);
						ret_q      <= ST_MSTEP;
						st_q       <= ST_Q0;
					end else begin
						sub_slot_q <= slot_of(off_q);
						ret_q      <= ST_FDONE;
						st_q       <= ST_P0;
					end
				end
				ST_MSTEP: begin
					off_q <= off_q & ~bs_cur;
					cur_q <= cur_q + OWD'(1);
					st_q  <= ST_MERGE;
				end
				ST_FDONE: begin
					done_q <= 1'b1;
					st_q   <= ST_IDLE;
				end
				ST_P0: begin
					h_q               <= head_q[sub_li];
					head_q[sub_li]    <= sub_slot_q;
					head_ok_q[sub_li] <= 1'b1;
					free_total_q      <= free_total_q + bud_pkg::BYTES_W'(bsz(sub_ord_q));
					st_q              <= head_ok_q[sub_li] ? ST_P1 : ret_q;
				end
				ST_P1: begin
					st_q <= ret_q;
				end
				ST_Q0: begin
					st_q <= ST_Q1;
				end
				ST_Q1: begin
					w_q <= rdata;
					if (!rdata[POK]) begin
						head_q[sub_li]    <= rdata[NXT_LO +: SW];
						head_ok_q[sub_li] <= rdata[NOK];
					end
					st_q <= ST_Q2;
				end
				ST_Q2: begin
					st_q <= ST_Q3;
				end
				ST_Q3: begin
					st_q <= ST_Q4;
				end
				ST_Q4: begin
					free_total_q <= free_total_q - bud_pkg::BYTES_W'(bsz(sub_ord_q));
					st_q         <= ret_q;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (st_q == ST_CLEAR && clr_q == SW'(HEAP_SLOTS - 1)) begin
				clr_init_q <= 1'b0;
			end
		end
	end

	assign busy      = (st_q != ST_IDLE);
	assign done      = done_q;
	assign result    = res_q;
	assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/bud_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bud_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bud_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== dv/buddy_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_allocator_tb: self-checking bench for the buddy allocator
// Drives init/alloc/free/report commands over several heap settings. A
// free-list predictor computes each result, and the scoreboard compares it
// field by field with every done pulse.
// ----------------------------------------------------------------------------
module buddy_allocator_tb;
	import bud_pkg::*;

	localparam int      MIN_ORD  = 5;
	localparam int      MAX_ORD  = 20;
	localparam int      SLOTS    = 131072;
	localparam int      N_ORD    = MAX_ORD - MIN_ORD + 1;
	localparam longint  M48      = 64'hFFFF_FFFF_FFFF;
	localparam int      LIMIT    = 3_000_000;

	// ------------------------------------------------------------------------
	// Scoreboard with its own free-list predictor
	// ------------------------------------------------------------------------
	class alloc_scoreboard;
		logic [ADDR_W-1:0]  base_reg, live_base;
		logic [BYTES_W-1:0] size_reg, live_size, free_total;
		longint             carved;
		int                 head [N_ORD];
		bit                 head_ok [N_ORD];
		int                 nxt [SLOTS];
		int                 prv [SLOTS];
		bit                 nxt_ok [SLOTS];
		bit                 prv_ok [SLOTS];
		int                 ord_of [SLOTS];
		bit                 fmark [SLOTS];
		logic [ADDR_W-1:0]  live_addr [$];
		res_t               expected [$];
		int                 errors, n_kind [4], n_fail;

		function new();
			base_reg = '0; size_reg = '0; live_base = '0; live_size = '0;
			free_total = '0; carved = 0; errors = 0; n_fail = 0;
			foreach (head_ok[i]) head_ok[i] = 0;
			foreach (fmark[i]) begin
				fmark[i] = 0; nxt_ok[i] = 0; prv_ok[i] = 0; ord_of[i] = 0;
			end
			foreach (n_kind[i]) n_kind[i] = 0;
		endfunction

		function void push_blk(int o, int s);
			int li;
			li = o - MIN_ORD;
			nxt_ok[s] = head_ok[li];
			nxt[s] = head[li];
			prv_ok[s] = 0;
			if (head_ok[li]) begin
				prv_ok[head[li]] = 1;
				prv[head[li]] = s;
			end
			head[li] = s;
			head_ok[li] = 1;
			ord_of[s] = o;
			fmark[s] = 1;
			free_total = free_total + BYTES_W'(64'd1 << o);
		endfunction

		function void pull_blk(int o, int s);
			int li;
			li = o - MIN_ORD;
			if (prv_ok[s]) begin
				nxt_ok[prv[s]] = nxt_ok[s];
				nxt[prv[s]] = nxt[s];
			end else begin
				head_ok[li] = nxt_ok[s];
				head[li] = nxt[s];
			end
			if (nxt_ok[s]) begin
				prv_ok[nxt[s]] = prv_ok[s];
				prv[nxt[s]] = prv[s];
			end
			nxt_ok[s] = 0;
			prv_ok[s] = 0;
			fmark[s] = 0;
			free_total = free_total - BYTES_W'(64'd1 << o);
		endfunction

		function void note_config(logic idx, logic [ADDR_W-1:0] data);
			if (idx == CFG_BASE) base_reg = data;
			else size_reg = data[BYTES_W-1:0];
		endfunction

		function longint slot_off(logic [ADDR_W-1:0] a);
			logic [ADDR_W-1:0] o;
			o = a - live_base - ADDR_W'(HDR_BYTES);
			return longint'(o);
		endfunction

		// free that never reads an unwritten order entry
		function bit free_is_safe(logic [ADDR_W-1:0] a);
			longint off;
			if (a == '0) return 1;
			off = slot_off(a);
			if (off[MIN_ORD-1:0] != 0 || off >= carved) return 1;
			if (fmark[off >> MIN_ORD]) return 1;
			foreach (live_addr[i]) if (live_addr[i] == a) return 1;
			return 0;
		endfunction

		function void carve();
			longint rem, off, bs, cap;
			cap = longint'(SLOTS) << MIN_ORD;
			live_base = base_reg;
			live_size = size_reg;
			rem = (longint'(live_size) < cap) ? longint'(live_size) : cap;
			carved = rem;
			off = 0;
			foreach (head_ok[i]) head_ok[i] = 0;
			foreach (fmark[i]) fmark[i] = 0;
			free_total = '0;
			live_addr.delete();
			for (int o = MAX_ORD; o >= MIN_ORD && rem > 0; o--) begin
				bs = longint'(1) << o;
				while (rem >= bs) begin
					push_blk(o, int'(off >> MIN_ORD));
					off += bs;
					rem -= bs;
				end
			end
		endfunction

		function bit take_block(logic [REQ_W-1:0] req, output logic [ADDR_W-1:0] a);
			longint need, off;
			int o, f, s;
			a = '0;
			if (req == '0) return 1;
			need = longint'(req) + HDR_BYTES;
			o = MIN_ORD;
			while (o <= MAX_ORD && (longint'(1) << o) < need) o++;
			if (o > MAX_ORD) return 1;
			f = o;
			while (f <= MAX_ORD && !head_ok[f - MIN_ORD]) f++;
			if (f > MAX_ORD) return 1;
			s = head[f - MIN_ORD];
			off = longint'(s) << MIN_ORD;
			pull_blk(f, s);
			while (f > o) begin
				f--;
				push_blk(f, int'((off + (longint'(1) << f)) >> MIN_ORD));
			end
			ord_of[s] = o;
			a = live_base + ADDR_W'(off) + ADDR_W'(HDR_BYTES);
			live_addr.push_back(a);
			return 0;
		endfunction

		function bit give_block(logic [ADDR_W-1:0] a);
			longint off, bs, bud;
			int o, bsl;
			if (a == '0) return 0;
			off = slot_off(a);
			if (off[MIN_ORD-1:0] != 0 || off >= carved) return 1;
			if (fmark[off >> MIN_ORD]) return 1;
			o = ord_of[off >> MIN_ORD];
			if (o < MIN_ORD || o > MAX_ORD) return 1;
			bs = longint'(1) << o;
			if ((off & (bs - 1)) != 0 || off + bs > carved) return 1;
			foreach (live_addr[i]) if (live_addr[i] == a) begin
				live_addr.delete(i);
				break;
			end
			while (o < MAX_ORD) begin
				bud = off ^ bs;
				if (bud + bs > carved) break;
				bsl = int'(bud >> MIN_ORD);
				if (!fmark[bsl] || ord_of[bsl] != o) break;
				pull_blk(o, bsl);
				if (bud < off) off = bud;
				o++;
				bs = bs << 1;
			end
			push_blk(o, int'(off >> MIN_ORD));
			return 0;
		endfunction

		function void note_request(cmd_t c);
			res_t r;
			logic [ADDR_W-1:0] a;
			r = '0;
			n_kind[c.kind]++;
			case (c.kind)
				KIND_INIT: carve();
				KIND_ALLOC: begin
					r.status = take_block(c.request_size, a);
					r.result_address = r.status ? '0 : a;
					if (r.status) n_fail++;
				end
				KIND_FREE: r.status = give_block(c.address);
				default: begin
					r.total_bytes = live_size;
					r.used_bytes  = live_size - free_total;
					r.free_bytes  = free_total;
				end
			endcase
			expected.push_back(r);
		endfunction

		function void check(res_t got);
			res_t e;
			if (expected.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			e = expected.pop_front();
			if (got.result_address !== e.result_address) begin
				$error("result_address exp %h got %h", e.result_address, got.result_address);
				errors++;
			end
			if (got.status !== e.status) begin
				$error("status exp %b got %b", e.status, got.status);
				errors++;
			end
			if (got.total_bytes !== e.total_bytes) begin
				$error("total_bytes exp %0d got %0d", e.total_bytes, got.total_bytes);
				errors++;
			end
			if (got.used_bytes !== e.used_bytes) begin
				$error("used_bytes exp %0d got %0d", e.used_bytes, got.used_bytes);
				errors++;
			end
			if (got.free_bytes !== e.free_bytes) begin
				$error("free_bytes exp %0d got %0d", e.free_bytes, got.free_bytes);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT and clocking
	// ------------------------------------------------------------------------
	logic              clk, arst_n, start, cfg_valid, cfg_index;
	logic [ADDR_W-1:0] cfg_data;
	cmd_t              cmd;
	res_t              result;
	logic              busy, done, cfg_ready;

	alloc_scoreboard sb;
	bit              quiet;  // no idle bursts in the closing stretch
	int              cycles;

	buddy_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// results cannot be held off: check every done pulse
	always @(posedge clk) begin
		if (arst_n && done) sb.check(result);
	end

	// run-away guard, counts from the very first edge (includes reset sweep)
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	// one request; start stays high when the next one follows with no gap
	task automatic issue(cmd_t c);
		int gap;
		gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		sb.note_request(c);
	endtask

	task automatic send(logic [KIND_W-1:0] k, logic [REQ_W-1:0] req,
			logic [ADDR_W-1:0] a);
		cmd_t c;
		c.kind = k;
		c.request_size = req;
		c.address = a;
		issue(c);
	endtask

	// let everything drain, then a write is safe
	task automatic drain();
		start <= 1'b0;
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [ADDR_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.note_config(idx, data);
	endtask

	task automatic new_heap(logic [ADDR_W-1:0] b, logic [BYTES_W-1:0] sz);
		drain();
		write_reg(CFG_BASE, b);
		write_reg(CFG_SIZE, {{(ADDR_W-BYTES_W){1'b0}}, sz});
		send(KIND_INIT, $urandom, {$urandom, $urandom});
	endtask

	function automatic logic [REQ_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 256);
		if (r < 90) return $urandom_range(257, 65536);
		if (r < 97) return $urandom_range(1, 1 << 20);
		return $urandom;
	endfunction

	// free address: mostly a live block, sometimes junk that is still legal
	function automatic logic [ADDR_W-1:0] pick_free();
		logic [ADDR_W-1:0] a;
		int r, o;
		r = $urandom_range(0, 99);
		if (r < 75 && sb.live_addr.size() != 0)
			return sb.live_addr[$urandom_range(0, sb.live_addr.size() - 1)];
		if (r < 82) return '0;
		if (r < 90) begin
			o = $urandom_range(0, N_ORD - 1);
			if (sb.head_ok[o])
				return sb.live_base + ADDR_W'(longint'(sb.head[o]) << MIN_ORD) + 8;
		end
		a = {$urandom, $urandom};
		if (r < 95 && sb.live_addr.size() != 0)
			a = sb.live_addr[0] + ADDR_W'($urandom_range(1, 31));
		return sb.free_is_safe(a) ? a : '0;
	endfunction

	task automatic random_run(int n);
		cmd_t c;
		int r;
		for (int i = 0; i < n; i++) begin
			c.request_size = $urandom;
			c.address = {$urandom, $urandom};
			r = $urandom_range(0, 99);
			if (r < 48) begin
				c.kind = KIND_ALLOC;
				c.request_size = pick_size();
			end else if (r < 90) begin
				c.kind = KIND_FREE;
				c.address = pick_free();
			end else begin
				c.kind = KIND_REPORT;
			end
			issue(c);
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		sb = new();
		cycles = 0;
		quiet = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BASE;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// before any init: empty lists
		send(KIND_REPORT, 0, 0);
		send(KIND_ALLOC, 64, 0);
		send(KIND_FREE, 0, 0);
		send(KIND_FREE, 0, 48'h1234_5678_9AB8);

		// empty heap
		new_heap(48'h0, 23'd0);
		send(KIND_ALLOC, 1, 0);
		send(KIND_REPORT, 0, 0);

		// odd size: leftover below one slot counts as used
		new_heap(48'h1000, 23'd1000);
		send(KIND_REPORT, 0, 0);
		send(KIND_ALLOC, 0, 0);
		send(KIND_ALLOC, 32'hFFFF_FFFF, 0);
		send(KIND_ALLOC, (1 << 20) - 8, 0);
		send(KIND_ALLOC, 1, 0);
		send(KIND_ALLOC, 24, 0);
		send(KIND_ALLOC, 25, 0);
		send(KIND_FREE, 0, 48'h1000 + 8 + 3);
		send(KIND_FREE, 0, sb.live_addr.size() ? sb.live_addr[0] : 48'h0);
		send(KIND_FREE, 0, pick_free());
		send(KIND_FREE, 0, 48'hFFFF_FFFF_FFFF);
		send(KIND_REPORT, 0, 0);
		random_run(200);

		// full capacity, base near the top so addresses wrap
		new_heap(48'hFFFF_FFFF_FFE0, 23'd4194304);
		send(KIND_ALLOC, (1 << 20) - 8, 0);
		send(KIND_ALLOC, (1 << 20) - 7, 0);
		send(KIND_REPORT, 0, 0);
		random_run(600);

		new_heap({$urandom, $urandom}, $urandom_range(0, 4194304));
		random_run(400);

		new_heap({$urandom, $urandom}, $urandom_range(200, 20000));
		random_run(200);
		quiet = 1;
		random_run(200);

		drain();
		$display("covered %0d init, %0d alloc (%0d failed), %0d free, %0d report",
			sb.n_kind[KIND_INIT], sb.n_kind[KIND_ALLOC], sb.n_fail,
			sb.n_kind[KIND_FREE], sb.n_kind[KIND_REPORT]);
		$display("heaps: empty, odd size, full capacity with wrapping base, two random");
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bud_pkg.sv
rtl/bud_ram.sv
rtl/buddy_allocator.sv
dv/buddy_allocator_tb.sv
